FILE: rtl/nrf_pkg.sv
// ----------------------------------------------------------------------------
// nrf_pkg
// Shared types, widths and constants for the nonce replay filter.
// ----------------------------------------------------------------------------
package nrf_pkg;

	localparam int ENTRIES_DEF = 64;

	localparam int TICKET_W = 32;
	localparam int NONCE_W  = 64;
	localparam int NOW_W    = 48;
	localparam int EXPIRY_W = NOW_W + 1;
	localparam int WIN_W    = 16;
	localparam int MSPS_W   = 10;
	localparam int WINMS_W  = WIN_W + MSPS_W;

	localparam logic [MSPS_W-1:0] MS_PER_S = MSPS_W'(1000);
	localparam logic [WIN_W-1:0]  WIN_RESET = WIN_W'(10);

	localparam int IN_DATA_W  = TICKET_W + NONCE_W + NOW_W;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [1:0] {
		V_STORED      = 2'd0,
		V_ZERO_TICKET = 2'd1,
		V_REPLAY      = 2'd2,
		V_FULL        = 2'd3
	} verdict_t;

	typedef struct packed {
		logic                valid;
		logic [EXPIRY_W-1:0] expiry;
		logic [NONCE_W-1:0]  nonce;
		logic [TICKET_W-1:0] ticket;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic addr_clr;
		logic addr_inc;
		logic clear_wr;
		logic load_req;
		logic rd_en;
		logic commit;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic addr_last;
		logic ticket_zero;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/nonce_replay_filter_core.sv
// ----------------------------------------------------------------------------
// nonce_replay_filter_core
// Anti-replay nonce cache with expiry, ENTRIES slots.
// ----------------------------------------------------------------------------
// Each item (ticket id, nonce, time in ms) yields one result item. A zero
// ticket goes straight to the hand-off step with no table access. Any other
// item sweeps every slot through the single read port of the slot RAM, one
// slot per cycle, purging expired slots and looking for a replay and the
// lowest free slot; a drain step, a commit step and a hand-off step follow,
// and items are taken one at a time. The result waits in an output register
// so the next item can be taken before it is drained. After reset the block
// runs a clearing pass over the slot RAM and holds s_tready low until it is
// done; the window register can be written at any time the block is idle.
// ----------------------------------------------------------------------------
module nonce_replay_filter_core #(
	parameter int ENTRIES = nrf_pkg::ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [nrf_pkg::WIN_W-1:0]      cfg_wdata,    // replay_window_s
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [nrf_pkg::IN_DATA_W-1:0]  s_tdata,      // ticket_id, nonce, now_ms
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [nrf_pkg::OUT_DATA_W-1:0] m_tdata       // accepted, verdict, zero pad
);

	nrf_pkg::cmd_t cmd;
	nrf_pkg::sts_t sts;

	nrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nrf_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: rtl/nrf_ram.sv
// ----------------------------------------------------------------------------
// nrf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/nrf_ctrl.sv
// ----------------------------------------------------------------------------
// nrf_ctrl
// Sequencer: clearing pass after reset, then per item a full table scan,
// a commit step and a hand-off to the output register (a zero ticket goes straight to the hand-off).
// ----------------------------------------------------------------------------
module nrf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  nrf_pkg::sts_t sts,
	output nrf_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_DRAIN  = 6'b001000,
		ST_FINISH = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				cmd.addr_inc = 1'b1;
				if (sts.addr_last) begin
					cmd.addr_clr = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.load_req = 1'b1;
					cmd.addr_clr = 1'b1;
					state_d      = sts.ticket_zero ? ST_RESULT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_inc = 1'b1;
				if (sts.addr_last) begin
					cmd.addr_clr = 1'b1;
					state_d      = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last read is checked this cycle
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.commit = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/nrf_datapath.sv
// ----------------------------------------------------------------------------
// nrf_datapath
// Slot table, request registers, expiry and match checks, output register.
// ----------------------------------------------------------------------------
module nrf_datapath #(
	parameter int ENTRIES = nrf_pkg::ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [nrf_pkg::WIN_W-1:0]        cfg_wdata,
	input  logic [nrf_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [nrf_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  nrf_pkg::cmd_t                    cmd,
	output nrf_pkg::sts_t                    sts
);

	localparam int IDX_W = $clog2(ENTRIES);

	logic [nrf_pkg::WIN_W-1:0]    win_q;
	logic [IDX_W-1:0]             addr_q;
	logic [nrf_pkg::TICKET_W-1:0] ticket_q;
	logic [nrf_pkg::NONCE_W-1:0]  nonce_q;
	logic [nrf_pkg::NOW_W-1:0]    now_q;
	logic [nrf_pkg::WINMS_W-1:0]  win_ms_q;
	logic                         zero_q;
	logic                         match_q;
	logic                         have_free_q;
	logic [IDX_W-1:0]             free_idx_q;
	logic                         rd_vld_s1;
	logic [IDX_W-1:0]             rd_addr_s1;
	logic                         m_tvalid_q;
	nrf_pkg::verdict_t            verdict_q;

	logic [nrf_pkg::TICKET_W-1:0] in_ticket;
	logic [nrf_pkg::NONCE_W-1:0]  in_nonce;
	logic [nrf_pkg::NOW_W-1:0]    in_now;
	logic [nrf_pkg::WIN_W-1:0]    win_eff;

	nrf_pkg::slot_t    rd_slot;
	nrf_pkg::slot_t    new_slot;
	nrf_pkg::slot_t    purged_slot;
	nrf_pkg::slot_t    wr_slot;
	logic              expired;
	logic              live;
	logic              hit;
	logic              purge_we;
	logic              commit_we;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	nrf_pkg::verdict_t verdict_c;

	assign in_ticket = s_tdata[nrf_pkg::TICKET_W-1:0];
	assign in_nonce  = s_tdata[nrf_pkg::TICKET_W +: nrf_pkg::NONCE_W];
	assign in_now    = s_tdata[nrf_pkg::TICKET_W + nrf_pkg::NONCE_W +: nrf_pkg::NOW_W];
	assign win_eff   = (win_q == '0) ? nrf_pkg::WIN_W'(1) : win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= nrf_pkg::WIN_RESET;
		end else if (cfg_wen) begin
			win_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.addr_clr) begin
			addr_q <= '0;
		end else if (cmd.addr_inc) begin
			addr_q <= addr_q + IDX_W'(1);
		end
	end

	// request registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			ticket_q <= in_ticket;
			nonce_q  <= in_nonce;
			now_q    <= in_now;
			win_ms_q <= nrf_pkg::WINMS_W'(win_eff * nrf_pkg::MS_PER_S);
		end
		if (cmd.rd_en) begin
			rd_addr_s1 <= addr_q;
		end
	end

	nrf_ram #(
		.WIDTH (nrf_pkg::SLOT_W),
		.DEPTH (ENTRIES)
	) u_slots (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (wr_slot),
		.re      (cmd.rd_en),
		.raddr   (addr_q),
		.rd_data (rd_slot)
	);

	assign expired = rd_slot.valid && (rd_slot.expiry <= {1'b0, now_q});
	assign live    = rd_slot.valid && !expired;
	assign hit     = live && (rd_slot.ticket == ticket_q) && (rd_slot.nonce == nonce_q);

	assign purge_we  = rd_vld_s1 && expired;
	assign commit_we = cmd.commit && !match_q && have_free_q;

	always_comb begin
		purged_slot       = rd_slot;
		purged_slot.valid = 1'b0;
		new_slot.valid    = 1'b1;
		new_slot.expiry   = {1'b0, now_q} + nrf_pkg::EXPIRY_W'(win_ms_q);
		new_slot.nonce    = nonce_q;
		new_slot.ticket   = ticket_q;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		wr_slot   = '0;
		priority if (cmd.clear_wr) begin
			ram_we = 1'b1;
		end else if (commit_we) begin
			ram_we    = 1'b1;
			ram_waddr = free_idx_q;
			wr_slot   = new_slot;
		end else if (purge_we) begin
			ram_we    = 1'b1;
			ram_waddr = rd_addr_s1;
			wr_slot   = purged_slot;
		end else begin
			ram_we = 1'b0;
		end
	end

	// scan bookkeeping: replay hit and lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			zero_q      <= 1'b0;
			match_q     <= 1'b0;
			have_free_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.load_req) begin
				zero_q      <= (in_ticket == '0);
				match_q     <= 1'b0;
				have_free_q <= 1'b0;
			end else if (rd_vld_s1) begin
				if (hit) begin
					match_q <= 1'b1;
				end
				if (!live && !have_free_q) begin
					have_free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !live && !have_free_q) begin
			free_idx_q <= rd_addr_s1;
		end
	end

	always_comb begin
		priority if (zero_q) begin
			verdict_c = nrf_pkg::V_ZERO_TICKET;
		end else if (match_q) begin
			verdict_c = nrf_pkg::V_REPLAY;
		end else if (!have_free_q) begin
			verdict_c = nrf_pkg::V_FULL;
		end else begin
			verdict_c = nrf_pkg::V_STORED;
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_result) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			verdict_q <= verdict_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, verdict_q, (verdict_q == nrf_pkg::V_STORED)};

	assign sts.addr_last   = (addr_q == IDX_W'(ENTRIES - 1));
	assign sts.ticket_zero = (in_ticket == '0);
	assign sts.out_free    = !m_tvalid_q || m_tready;

`ifndef ASSERT_OFF
	a_commit_no_purge: assert property (@(posedge clk) disable iff (!arst_n)
		!(commit_we && purge_we))
		else $error("commit write collides with a purge write");

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> !rd_vld_s1 && !cmd.rd_en)
		else $error("result loaded while the scan is still running");

	a_commit_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !rd_vld_s1 && $past(rd_vld_s1, 2))
		else $error("commit issued before the last slot was checked");
`endif

endmodule
